>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk with rst_n as disable; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SPF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("spf assertion failed");

`define SPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spf assertion failed");

`else

`define SPF_ASSERT(lbl, prop)

`define SPF_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

>>> rtl/core/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared constants and codes of the smallest prime factor sieve.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int TABLE_SIZE  = 65536;
  localparam int ADDR_W      = $clog2(TABLE_SIZE);
  localparam int DATA_W      = 16;
  localparam int NUM_W       = 16;
  localparam int REQ_W       = 2;
  localparam int ST_W        = 2;
  localparam int LIM_MAX     = (TABLE_SIZE - 1 < 65535) ? TABLE_SIZE - 1 : 65535;
  localparam int FIRST_PRIME = 2;
  localparam int MAX_RES     = 16;
  localparam int K_W         = $clog2(MAX_RES + 1);
  localparam int P_W         = 9;
  localparam int M_W         = NUM_W + 1;

  localparam logic [REQ_W-1:0] REQ_BUILD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALL      = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DISTINCT = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNBUILT = 2'd2;

endpackage

>>> rtl/core/spf_if.sv
// ----------------------------------------------------------------------------
// spf channel interfaces
// Valid/ready channels for requests, results and the limit register write.
// ----------------------------------------------------------------------------
interface spf_in_if
  import spf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [NUM_W-1:0] number;

  modport source (output valid, req_type, number, input ready);
  modport sink (input valid, req_type, number, output ready);
endinterface

interface spf_out_if
  import spf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] factor;
  logic              last;
  logic [ST_W-1:0]   status;

  modport source (output valid, factor, last, status, input ready);
  modport sink (input valid, factor, last, status, output ready);
endinterface

interface spf_cfg_if
  import spf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] sieve_limit;

  modport source (output valid, sieve_limit, input ready);
  modport sink (input valid, sieve_limit, output ready);
endinterface

>>> rtl/core/spf_ram.sv
// ----------------------------------------------------------------------------
// spf_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/spf_div.sv
// ----------------------------------------------------------------------------
// spf_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module spf_div
  import spf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [NUM_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W:0]   rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [NUM_W-1:0] dvs_r, dvs_nxt;
  logic [NUM_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[NUM_W-1:0], quo_r[NUM_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/smallest_prime_factor_sieve.sv
// Build: seeds entries 0..lim with their own index, then reads each candidate prime p with
//   p*p <= lim and visits the multiples of each prime found; one result when the sieve ends.
// Query: per prime factor a table read, an emit and a divide by it, then a last result in S_QEND.
// Errors and unbuilt queries: one result, pushed from S_QEND.
// One request at a time; the output register lets the next request in.
// Reset idles control, clears the built flag and sets the limit to 65535; table kept.
// ----------------------------------------------------------------------------
// smallest_prime_factor_sieve
// Sieve table in one RAM with read-check-write sequencing and factor streaming.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smallest_prime_factor_sieve
  import spf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  spf_in_if.sink    in_chan,
  spf_out_if.source out_chan,
  spf_cfg_if.sink   cfg_chan
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INIT  = 4'd1;
  localparam logic [3:0] S_PTEST = 4'd2;
  localparam logic [3:0] S_PWAIT = 4'd3;
  localparam logic [3:0] S_MRD   = 4'd4;
  localparam logic [3:0] S_MCHK  = 4'd5;
  localparam logic [3:0] S_QRD   = 4'd6;
  localparam logic [3:0] S_QCHK  = 4'd7;
  localparam logic [3:0] S_QEMIT = 4'd8;
  localparam logic [3:0] S_QDIV  = 4'd9;
  localparam logic [3:0] S_QEND  = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [NUM_W-1:0]  sieve_limit_r, sieve_limit_nxt;
  logic [NUM_W-1:0]  built_limit_r, built_limit_nxt;
  logic              table_built_r, table_built_nxt;
  logic [NUM_W-1:0]  lim_r, lim_nxt;
  logic [NUM_W-1:0]  idx_r, idx_nxt;
  logic [P_W-1:0]    p_r, p_nxt;
  logic [M_W-1:0]    m_r, m_nxt;
  logic [NUM_W-1:0]  n_r, n_nxt;
  logic              req_all_r, req_all_nxt;
  logic [DATA_W-1:0] fac_r, fac_nxt;
  logic [DATA_W-1:0] prev_r, prev_nxt;
  logic [DATA_W-1:0] pend_fac_r, pend_fac_nxt;
  logic [ST_W-1:0]   pend_st_r, pend_st_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_factor_r, out_factor_nxt;
  logic              out_last_r, out_last_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;

  logic              in_fire;
  logic              out_free;
  logic              push;
  logic              push_last;
  logic              emit;
  logic [2*P_W-1:0]  psq;
  logic [NUM_W-1:0]  lim_clamp;

  spf_ram #(
    .WIDTH(DATA_W),
    .DEPTH(TABLE_SIZE)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  spf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(n_r),
    .divisor (fac_r),
    .done    (div_done),
    .quotient(div_quo)
  );

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;
  assign psq            = p_r * p_r;
  assign emit           = req_all_r || (fac_r != prev_r);

  always_comb begin
    if (sieve_limit_r < NUM_W'(FIRST_PRIME)) begin
      lim_clamp = NUM_W'(FIRST_PRIME);
    end else if (sieve_limit_r > NUM_W'(LIM_MAX)) begin
      lim_clamp = NUM_W'(LIM_MAX);
    end else begin
      lim_clamp = sieve_limit_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    sieve_limit_nxt = sieve_limit_r;
    built_limit_nxt = built_limit_r;
    table_built_nxt = table_built_r;
    lim_nxt         = lim_r;
    idx_nxt         = idx_r;
    p_nxt           = p_r;
    m_nxt           = m_r;
    n_nxt           = n_r;
    req_all_nxt     = req_all_r;
    fac_nxt         = fac_r;
    prev_nxt        = prev_r;
    pend_fac_nxt    = pend_fac_r;
    pend_st_nxt     = pend_st_r;
    k_nxt           = k_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    div_start       = 1'b0;
    push            = 1'b0;
    push_last       = 1'b0;

    if (cfg_chan.valid && cfg_chan.ready) begin
      sieve_limit_nxt = cfg_chan.sieve_limit;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.req_type)
            REQ_BUILD: begin
              lim_nxt   = lim_clamp;
              idx_nxt   = '0;
              state_nxt = S_INIT;
            end
            REQ_ALL, REQ_DISTINCT: begin
              req_all_nxt = (in_chan.req_type == REQ_ALL);
              n_nxt       = in_chan.number;
              prev_nxt    = '0;
              k_nxt       = '0;
              pend_fac_nxt = '0;
              if (!table_built_r) begin
                pend_st_nxt = ST_UNBUILT;
                state_nxt   = S_QEND;
              end else if (in_chan.number < NUM_W'(FIRST_PRIME) ||
                           in_chan.number > built_limit_r) begin
                pend_st_nxt = ST_RANGE;
                state_nxt   = S_QEND;
              end else begin
                state_nxt = S_QRD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(idx_r);
        ram_wdata = DATA_W'(idx_r);
        if (idx_r == lim_r) begin
          p_nxt     = P_W'(FIRST_PRIME);
          state_nxt = S_PTEST;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_PTEST: begin
        if (psq > (2*P_W)'(lim_r)) begin
          table_built_nxt = 1'b1;
          built_limit_nxt = lim_r;
          pend_fac_nxt    = '0;
          pend_st_nxt     = ST_OK;
          state_nxt       = S_QEND;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(p_r);
          state_nxt = S_PWAIT;
        end
      end
      S_PWAIT: begin
        if (ram_rdata == DATA_W'(p_r)) begin
          m_nxt     = M_W'(p_r) << 1;
          state_nxt = S_MRD;
        end else begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_PTEST;
        end
      end
      S_MRD: begin
        if (m_r > M_W'(lim_r)) begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_PTEST;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(m_r);
          state_nxt = S_MCHK;
        end
      end
      S_MCHK: begin
        if (ram_rdata == DATA_W'(m_r)) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(m_r);
          ram_wdata = DATA_W'(p_r);
        end
        m_nxt     = m_r + M_W'(p_r);
        state_nxt = S_MRD;
      end
      S_QRD: begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(n_r);
        state_nxt = S_QCHK;
      end
      S_QCHK: begin
        if (ram_rdata < DATA_W'(FIRST_PRIME) || ram_rdata > DATA_W'(n_r)) begin
          fac_nxt = DATA_W'(n_r);
        end else begin
          fac_nxt = ram_rdata;
        end
        state_nxt = S_QEMIT;
      end
      S_QEMIT: begin
        if (!(emit && k_r != '0 && !out_free)) begin
          if (emit) begin
            push         = (k_r != '0);
            pend_fac_nxt = fac_r;
            pend_st_nxt  = ST_OK;
            k_nxt        = k_r + 1'b1;
          end
          prev_nxt  = fac_r;
          div_start = 1'b1;
          state_nxt = S_QDIV;
        end
      end
      S_QDIV: begin
        if (div_done) begin
          n_nxt = div_quo;
          if (div_quo == NUM_W'(1) || k_r == K_W'(MAX_RES)) begin
            state_nxt = S_QEND;
          end else begin
            state_nxt = S_QRD;
          end
        end
      end
      S_QEND: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_factor_nxt = out_factor_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    if (push) begin
      out_valid_nxt  = 1'b1;
      out_factor_nxt = pend_fac_r;
      out_last_nxt   = push_last;
      out_status_nxt = pend_st_r;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sieve_limit_r <= NUM_W'(65535);
      built_limit_r <= '0;
      table_built_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sieve_limit_r <= sieve_limit_nxt;
      built_limit_r <= built_limit_nxt;
      table_built_r <= table_built_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lim_r        <= lim_nxt;
    idx_r        <= idx_nxt;
    p_r          <= p_nxt;
    m_r          <= m_nxt;
    n_r          <= n_nxt;
    req_all_r    <= req_all_nxt;
    fac_r        <= fac_nxt;
    prev_r       <= prev_nxt;
    pend_fac_r   <= pend_fac_nxt;
    pend_st_r    <= pend_st_nxt;
    k_r          <= k_nxt;
    out_factor_r <= out_factor_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.factor = out_factor_r;
  assign out_chan.last   = out_last_r;
  assign out_chan.status = out_status_r;

  `SPF_ASSERT_IMP(a_wr_only_in_build, ram_we, state_r == S_INIT || state_r == S_MCHK)
  `SPF_ASSERT_IMP(a_div_done_in_wait, div_done, state_r == S_QDIV)
  `SPF_ASSERT(a_k_bounded, k_r <= K_W'(MAX_RES))
  `SPF_ASSERT_IMP(a_built_from_sieve, $rose(table_built_r), $past(state_r) == S_PTEST)

endmodule
